// ===== rtl/ifd_pkg.sv =====
// shared types, constants and the crc helper of the frame decoder
package ifd_pkg;

  localparam logic [5:0]  HDR_BYTES   = 6'd16;
  localparam logic [5:0]  IMU_SIZE    = 6'd44;
  localparam logic [5:0]  WHEEL_SIZE  = 6'd28;
  localparam logic [15:0] CRC_POLY    = 16'h1021;

  typedef enum logic [1:0] {
    REG_SYNC       = 2'd0,
    REG_IMU_ID     = 2'd1,
    REG_WHEEL_ID   = 2'd2,
    REG_FRAME_KIND = 2'd3
  } ifd_reg_t;

  typedef enum logic [1:0] {
    OP_SYNC,
    OP_HDR,
    OP_WORD,
    OP_FOOT
  } ifd_op_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_SYNC     = 3'd1,
    ST_BAD_ID       = 3'd2,
    ST_LEN_MISMATCH = 3'd3,
    ST_CRC_MISMATCH = 3'd4
  } ifd_status_t;

  typedef enum logic {
    RES_WORD   = 1'b0,
    RES_FINISH = 1'b1
  } ifd_res_kind_t;

  typedef enum logic {
    PH_IDLE,
    PH_ACTIVE
  } ifd_phase_t;

  // one classified byte, handed from the parser to the execution side
  typedef struct packed {
    logic        clear;
    logic        crc_en;
    ifd_op_t     op;
    logic [7:0]  data;
    logic [3:0]  hdr_pos;
    logic        sync_bad;
    logic        id_bad;
    logic        word_done;
    logic [2:0]  word_idx;
    logic [1:0]  foot_off;
    logic        last;
    logic [5:0]  size;
  } ifd_cmd_t;

  typedef struct packed {
    ifd_res_kind_t kind;
    logic [2:0]    word_index;
    logic [31:0]   word_value;
    logic [7:0]    message_type;
    logic [7:0]    frame_seq;
    logic [7:0]    trig_src;
    logic [15:0]   message_length;
    logic [15:0]   week_num;
    logic [31:0]   gps_seconds;
    logic [31:0]   gps_microseconds;
    logic [15:0]   foot_status;
    ifd_status_t   status;
  } ifd_res_t;

  // crc-16, msb first, one byte
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] v;
    v = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (v[15]) begin
        v = {v[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        v = {v[14:0], 1'b0};
      end
    end
    return v;
  endfunction

endpackage

// ===== rtl/ifd_fifo.sv =====
// small show-ahead queue used between the parser, the executor and the result port
module ifd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + CW'(1);
      2'b01:   count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

  a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue count did not follow a lone push");

endmodule

// ===== rtl/ifd_front.sv =====
// parser: configuration registers, frame position tracking and byte classification
module ifd_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [7:0]      cfg_wdata,
  input  logic            accept,
  input  logic [7:0]      in_data_byte,
  input  logic            in_start_of_message,
  output logic            cmd_valid,
  output ifd_pkg::ifd_cmd_t cmd
);
  import ifd_pkg::*;

  ifd_phase_t  state_r, state_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic [7:0]  sync_r, imu_id_r, wheel_id_r;
  logic        kind_r;

  logic [5:0]  pos, size, word_off, foot_raw;
  logic [7:0]  want_id;
  logic        end_frame;

  assign pos      = in_start_of_message ? 6'd0 : pos_r;
  assign size     = kind_r ? WHEEL_SIZE : IMU_SIZE;
  assign want_id  = kind_r ? wheel_id_r : imu_id_r;
  assign word_off = pos - HDR_BYTES;
  assign foot_raw = pos - (size - 6'd4);

  always_comb begin
    cmd.clear     = in_start_of_message;
    cmd.crc_en    = (pos < size - 6'd2);
    cmd.data      = in_data_byte;
    cmd.hdr_pos   = pos[3:0];
    cmd.sync_bad  = (in_data_byte != sync_r);
    cmd.id_bad    = (pos == 6'd1) && (in_data_byte != want_id);
    cmd.word_done = (word_off[1:0] == 2'b11);
    cmd.word_idx  = word_off[4:2];
    cmd.foot_off  = (foot_raw > 6'd3) ? 2'd3 : foot_raw[1:0];
    cmd.last      = (pos >= size - 6'd1);
    cmd.size      = size;
    if (pos == 6'd0) begin
      cmd.op = OP_SYNC;
    end else if (pos < HDR_BYTES) begin
      cmd.op = OP_HDR;
    end else if (pos < size - 6'd4) begin
      cmd.op = OP_WORD;
    end else begin
      cmd.op = OP_FOOT;
    end
  end

  assign cmd_valid = accept && (in_start_of_message || state_r == PH_ACTIVE);

  always_comb begin
    end_frame = 1'b0;
    case (cmd.op)
      OP_SYNC: end_frame = cmd.sync_bad;
      OP_HDR:  end_frame = cmd.id_bad;
      OP_FOOT: end_frame = cmd.last;
      default: end_frame = 1'b0;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pos_nxt   = pos_r;
    if (cmd_valid) begin
      pos_nxt   = end_frame ? 6'd0 : pos + 6'd1;
      state_nxt = end_frame ? PH_IDLE : PH_ACTIVE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PH_IDLE;
      pos_r   <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r     <= 8'h7E;
      imu_id_r   <= '0;
      wheel_id_r <= '0;
      kind_r     <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SYNC:       sync_r     <= cfg_wdata;
        REG_IMU_ID:     imu_id_r   <= cfg_wdata;
        REG_WHEEL_ID:   wheel_id_r <= cfg_wdata;
        REG_FRAME_KIND: kind_r     <= cfg_wdata[0];
        default:        ;
      endcase
    end
  end

  a_end_goes_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_valid && end_frame) |=> (state_r == PH_IDLE))
    else $error("parser stayed active after a frame ended");

  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == PH_ACTIVE) |-> (pos_r < IMU_SIZE))
    else $error("frame position ran past the longest frame");

endmodule

// ===== rtl/ifd_back.sv =====
// executor: crc, header and footer capture, word assembly and result building
module ifd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_valid,
  input  ifd_pkg::ifd_cmd_t cmd,
  output logic              cmd_pop,
  input  logic              res_full,
  output logic              res_push,
  output ifd_pkg::ifd_res_t res
);
  import ifd_pkg::*;

  logic [15:0] crc_r, crc_nxt, crc_base;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  mtype_r, mtype_nxt;
  logic [7:0]  fcnt_r, fcnt_nxt;
  logic [7:0]  trig_r, trig_nxt;
  logic [15:0] week_r, week_nxt;
  logic [31:0] secs_r, secs_nxt;
  logic [31:0] usecs_r, usecs_nxt;
  logic [31:0] word_r, word_nxt;
  logic [15:0] gstat_r, gstat_nxt;
  logic [15:0] rxcrc_r, rxcrc_nxt;
  logic        res_valid;

  assign cmd_pop  = cmd_valid && !res_full;
  assign res_push = cmd_pop && res_valid;

  always_comb begin
    // a start marker clears the frame before this byte is applied
    crc_base  = cmd.clear ? '0 : crc_r;
    len_nxt   = cmd.clear ? '0 : len_r;
    mtype_nxt = cmd.clear ? '0 : mtype_r;
    fcnt_nxt  = cmd.clear ? '0 : fcnt_r;
    trig_nxt  = cmd.clear ? '0 : trig_r;
    week_nxt  = cmd.clear ? '0 : week_r;
    secs_nxt  = cmd.clear ? '0 : secs_r;
    usecs_nxt = cmd.clear ? '0 : usecs_r;
    word_nxt  = cmd.clear ? '0 : word_r;
    gstat_nxt = cmd.clear ? '0 : gstat_r;
    rxcrc_nxt = cmd.clear ? '0 : rxcrc_r;
    crc_nxt   = cmd.crc_en ? crc16_byte(crc_base, cmd.data) : crc_base;

    res_valid            = 1'b0;
    res.kind             = RES_FINISH;
    res.word_index       = '0;
    res.word_value       = '0;
    res.foot_status      = '0;
    res.status           = ST_OK;

    case (cmd.op)
      OP_SYNC: begin
        if (cmd.sync_bad) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_SYNC;
        end
      end
      OP_HDR: begin
        case (cmd.hdr_pos)
          4'd1:    mtype_nxt          = cmd.data;
          4'd2:    fcnt_nxt           = cmd.data;
          4'd3:    trig_nxt           = cmd.data;
          4'd4:    len_nxt[7:0]       = cmd.data;
          4'd5:    len_nxt[15:8]      = cmd.data;
          4'd6:    week_nxt[7:0]      = cmd.data;
          4'd7:    week_nxt[15:8]     = cmd.data;
          4'd8:    secs_nxt[7:0]      = cmd.data;
          4'd9:    secs_nxt[15:8]     = cmd.data;
          4'd10:   secs_nxt[23:16]    = cmd.data;
          4'd11:   secs_nxt[31:24]    = cmd.data;
          4'd12:   usecs_nxt[7:0]     = cmd.data;
          4'd13:   usecs_nxt[15:8]    = cmd.data;
          4'd14:   usecs_nxt[23:16]   = cmd.data;
          4'd15:   usecs_nxt[31:24]   = cmd.data;
          default: ;
        endcase
        if (cmd.id_bad) begin
          res_valid  = 1'b1;
          res.status = ST_BAD_ID;
        end
      end
      OP_WORD: begin
        word_nxt = {cmd.data, word_nxt[31:8]};
        if (cmd.word_done) begin
          res_valid      = 1'b1;
          res.kind       = RES_WORD;
          res.word_index = cmd.word_idx;
          res.word_value = word_nxt;
        end
      end
      OP_FOOT: begin
        case (cmd.foot_off)
          2'd0:    gstat_nxt[7:0]  = cmd.data;
          2'd1:    gstat_nxt[15:8] = cmd.data;
          2'd2:    rxcrc_nxt[7:0]  = cmd.data;
          default: rxcrc_nxt[15:8] = cmd.data;
        endcase
        if (cmd.last) begin
          res_valid       = 1'b1;
          res.foot_status = gstat_nxt;
          // length check wins over the crc check
          if (len_nxt != {10'd0, cmd.size}) begin
            res.status = ST_LEN_MISMATCH;
          end else if (crc_nxt != rxcrc_nxt) begin
            res.status = ST_CRC_MISMATCH;
          end else begin
            res.status = ST_OK;
          end
        end
      end
      default: ;
    endcase

    res.message_type     = mtype_nxt;
    res.frame_seq        = fcnt_nxt;
    res.trig_src         = trig_nxt;
    res.message_length   = len_nxt;
    res.week_num         = week_nxt;
    res.gps_seconds      = secs_nxt;
    res.gps_microseconds = usecs_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r   <= '0;
      len_r   <= '0;
      mtype_r <= '0;
      fcnt_r  <= '0;
      trig_r  <= '0;
      week_r  <= '0;
      secs_r  <= '0;
      usecs_r <= '0;
      word_r  <= '0;
      gstat_r <= '0;
      rxcrc_r <= '0;
    end else if (cmd_pop) begin
      crc_r   <= crc_nxt;
      len_r   <= len_nxt;
      mtype_r <= mtype_nxt;
      fcnt_r  <= fcnt_nxt;
      trig_r  <= trig_nxt;
      week_r  <= week_nxt;
      secs_r  <= secs_nxt;
      usecs_r <= usecs_nxt;
      word_r  <= word_nxt;
      gstat_r <= gstat_nxt;
      rxcrc_r <= rxcrc_nxt;
    end
  end

  a_word_emits: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd_pop && cmd.op == OP_WORD && cmd.word_done) |-> res_push)
    else $error("completed payload word produced no result");

endmodule

// ===== rtl/ins_frame_decoder_crc16_unit.sv =====
// Byte-serial frame decoder with CRC-16 check. One byte is taken per clock while full is low;
// a parser classifies each frame byte against the selected frame layout and queues it, and an
// executor updates the CRC (one byte per cycle unless the result queue is full), captures
// header and footer fields and assembles payload words. A result (payload word or frame
// finish) enters the output queue as the executor takes its byte. Sustained rate is one byte
// per cycle while the result queue has room, set by the byte-wide CRC update. No clearing
// pass after reset. Configuration is written through cfg_we, cfg_index and cfg_wdata.
module ins_frame_decoder_crc16_unit #(
  parameter int unsigned CMD_DEPTH = 2,
  parameter int unsigned RES_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_start_of_message,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind,
  output logic [2:0]  out_word_index,
  output logic [31:0] out_word_value,
  output logic [7:0]  out_message_type,
  output logic [7:0]  out_frame_seq,
  output logic [7:0]  out_trig_src,
  output logic [15:0] out_message_length,
  output logic [15:0] out_week_num,
  output logic [31:0] out_gps_seconds,
  output logic [31:0] out_gps_microseconds,
  output logic [15:0] out_foot_status,
  output logic [2:0]  out_status
);
  import ifd_pkg::*;

  logic     accept;
  logic     fr_valid;
  ifd_cmd_t fr_cmd;
  ifd_cmd_t q_cmd;
  logic     q_empty;
  logic     q_pop;
  logic     res_full;
  logic     res_push;
  ifd_res_t res_in;
  ifd_res_t res_out;

  assign accept = push && !full;

  ifd_front u_front (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .accept              (accept),
    .in_data_byte        (in_data_byte),
    .in_start_of_message (in_start_of_message),
    .cmd_valid           (fr_valid),
    .cmd                 (fr_cmd)
  );

  ifd_fifo #(
    .WIDTH ($bits(ifd_cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .wdata (fr_cmd),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_cmd),
    .empty (q_empty)
  );

  ifd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (!q_empty),
    .cmd       (q_cmd),
    .cmd_pop   (q_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  ifd_fifo #(
    .WIDTH ($bits(ifd_res_t)),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign out_kind             = res_out.kind;
  assign out_word_index       = res_out.word_index;
  assign out_word_value       = res_out.word_value;
  assign out_message_type     = res_out.message_type;
  assign out_frame_seq        = res_out.frame_seq;
  assign out_trig_src         = res_out.trig_src;
  assign out_message_length   = res_out.message_length;
  assign out_week_num         = res_out.week_num;
  assign out_gps_seconds      = res_out.gps_seconds;
  assign out_gps_microseconds = res_out.gps_microseconds;
  assign out_foot_status      = res_out.foot_status;
  assign out_status           = res_out.status;

endmodule
